// ----- sv/strided_view_address_gen_top_macros.svh -----
// Assertion macros for the strided view address generator.
`ifndef STRIDED_VIEW_ADDRESS_GEN_TOP_MACROS_SVH
`define STRIDED_VIEW_ADDRESS_GEN_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define SVAG_ASSERT_IMP(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("svag assertion failed");
`define SVAG_ASSERT_NXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("svag assertion failed");
`else
`define SVAG_ASSERT_IMP(label, clk, rst_n, lhs, rhs)
`define SVAG_ASSERT_NXT(label, clk, rst_n, lhs, rhs)
`endif
`endif

// ----- sv/svag_pkg.sv -----
// Shared types, constants and field helpers of the strided view address generator.
package svag_pkg;

    localparam int MAX_RANK_DEF    = 4;
    localparam int SIZE_BITS_DEF   = 16;
    localparam int STRIDE_BITS_DEF = 32;
    localparam int POS_BITS_DEF    = 48;

    localparam int IDX_BITS  = 64;
    localparam int RANK_BITS = 3;
    localparam int REG_BITS  = 64;
    localparam int ADDR_BITS = 6;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_RANK     = 3'd0;
    localparam logic [2:0] REG_BASE     = 3'd1;
    localparam logic [2:0] REG_LIMIT    = 3'd2;
    localparam logic [2:0] REG_SIZES    = 3'd3;
    localparam logic [2:0] REG_STR_LOW  = 3'd4;
    localparam logic [2:0] REG_STR_HIGH = 3'd5;

    // Result status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_RANGE   = 2'd1;
    localparam logic [1:0] ST_STORAGE = 2'd2;

    // Control carried along the cell chain with each request.
    typedef struct packed {
        logic valid;
        logic err;
    } t_ctrl;

    // Field of a packed register word; fields past the word read as zero.
    function automatic logic [63:0] field_at(logic [63:0] word, int lsb, int bits);
        logic [63:0] mask;
        mask = (bits >= 64) ? '1 : ((64'd1 << bits) - 64'd1);
        if (lsb >= 64) begin
            return '0;
        end
        return (word >> lsb) & mask;
    endfunction

endpackage

// ----- sv/strided_view_address_gen_top.sv -----
// Strided view address generator: flat index to storage position, with checks.
//
// The block takes one flat index in every cycle and returns one result per index,
// in order. Each axis, last axis first, owns a row of 64 division cells that
// produce one quotient bit each, followed by a two-stage multiply-accumulate cell;
// that chain sets the latency. busy stays low, so a request is taken in any cycle,
// and the result strobe o_valid must be sampled when it is high since it cannot be
// held. The user must write configuration through the APB port only while no
// request is in flight; the block itself does not enforce this.
`include "strided_view_address_gen_top_macros.svh"

module strided_view_address_gen_top #(
    parameter int MAX_RANK    = svag_pkg::MAX_RANK_DEF,
    parameter int SIZE_BITS   = svag_pkg::SIZE_BITS_DEF,
    parameter int STRIDE_BITS = svag_pkg::STRIDE_BITS_DEF,
    parameter int POS_BITS    = svag_pkg::POS_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [svag_pkg::IDX_BITS-1:0]  i_flat_index,
    output logic                           o_valid,
    output logic [POS_BITS-1:0]            o_storage_position,
    output logic [1:0]                     o_status,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [svag_pkg::ADDR_BITS-1:0] paddr,
    input  logic [svag_pkg::REG_BITS-1:0]  pwdata,
    output logic [svag_pkg::REG_BITS-1:0]  prdata,
    output logic                           pready
);

    localparam int HOPS = svag_pkg::IDX_BITS + 1;
    localparam int NS   = MAX_RANK * HOPS;

    logic [svag_pkg::RANK_BITS-1:0] r_rank;
    logic [POS_BITS-1:0]            r_base;
    logic [POS_BITS-1:0]            r_limit;
    logic [svag_pkg::REG_BITS-1:0]  r_sizes;
    logic [svag_pkg::REG_BITS-1:0]  r_str_low;
    logic [svag_pkg::REG_BITS-1:0]  r_str_high;

    logic [2:0]                     reg_idx;
    logic                           wr_en;

    svag_pkg::t_ctrl                s_ctrl [0:NS];
    logic [svag_pkg::IDX_BITS-1:0]  s_word [0:NS];
    logic [SIZE_BITS-1:0]           s_rem  [0:NS];
    logic [POS_BITS-1:0]            s_at   [0:NS];

    logic [MAX_RANK-1:0]            zero_hit;
    logic                           err_range;
    logic [1:0]                     n_status;

    logic                           r_valid;
    logic [1:0]                     r_status;
    logic [POS_BITS-1:0]            r_pos;

    // Configuration port.
    assign pready  = 1'b1;
    assign busy    = 1'b0;
    assign reg_idx = paddr[svag_pkg::ADDR_BITS-1:3];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rank     <= '0;
            r_base     <= '0;
            r_limit    <= '0;
            r_sizes    <= '0;
            r_str_low  <= '0;
            r_str_high <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                svag_pkg::REG_RANK:     r_rank     <= pwdata[svag_pkg::RANK_BITS-1:0];
                svag_pkg::REG_BASE:     r_base     <= pwdata[POS_BITS-1:0];
                svag_pkg::REG_LIMIT:    r_limit    <= pwdata[POS_BITS-1:0];
                svag_pkg::REG_SIZES:    r_sizes    <= pwdata;
                svag_pkg::REG_STR_LOW:  r_str_low  <= pwdata;
                svag_pkg::REG_STR_HIGH: r_str_high <= pwdata;
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        case (reg_idx)
            svag_pkg::REG_RANK:     prdata = svag_pkg::REG_BITS'(r_rank);
            svag_pkg::REG_BASE:     prdata = svag_pkg::REG_BITS'(r_base);
            svag_pkg::REG_LIMIT:    prdata = svag_pkg::REG_BITS'(r_limit);
            svag_pkg::REG_SIZES:    prdata = r_sizes;
            svag_pkg::REG_STR_LOW:  prdata = r_str_low;
            svag_pkg::REG_STR_HIGH: prdata = r_str_high;
            default:                prdata = '0;
        endcase
    end

    // Head of the chain: a new request enters in every cycle that start is high.
    assign s_ctrl[0].valid = start && !busy;
    assign s_ctrl[0].err   = 1'b0;
    assign s_word[0]       = i_flat_index;
    assign s_rem[0]        = '0;
    assign s_at[0]         = r_base;

    // One row of division cells and one multiply-accumulate cell per axis.
    for (genvar k = 0; k < MAX_RANK; k++) begin : g_axis
        localparam int AX = MAX_RANK - 1 - k;
        localparam int B  = k * HOPS;

        logic                   used;
        logic [SIZE_BITS-1:0]   size;
        logic [STRIDE_BITS-1:0] stride;

        assign used = (r_rank > svag_pkg::RANK_BITS'(AX));
        assign size = SIZE_BITS'(svag_pkg::field_at(r_sizes, AX * SIZE_BITS, SIZE_BITS));

        if (AX < 2) begin : g_low
            assign stride = STRIDE_BITS'(svag_pkg::field_at(
                r_str_low, (AX % 2) * STRIDE_BITS, STRIDE_BITS));
        end else if (AX < 4) begin : g_high
            assign stride = STRIDE_BITS'(svag_pkg::field_at(
                r_str_high, (AX % 2) * STRIDE_BITS, STRIDE_BITS));
        end else begin : g_none
            assign stride = '0;
        end

        assign zero_hit[k] = used && (size == '0);

        for (genvar j = 0; j < svag_pkg::IDX_BITS; j++) begin : g_div
            svag_div_cell #(
                .SIZE_BITS (SIZE_BITS),
                .POS_BITS  (POS_BITS)
            ) u_div (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (used),
                .i_size  (size),
                .i_ctrl  (s_ctrl[B+j]),
                .i_word  (s_word[B+j]),
                .i_rem   (s_rem[B+j]),
                .i_at    (s_at[B+j]),
                .o_ctrl  (s_ctrl[B+j+1]),
                .o_word  (s_word[B+j+1]),
                .o_rem   (s_rem[B+j+1]),
                .o_at    (s_at[B+j+1])
            );
        end

        svag_mac_cell #(
            .SIZE_BITS   (SIZE_BITS),
            .STRIDE_BITS (STRIDE_BITS),
            .POS_BITS    (POS_BITS)
        ) u_mac (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_stride (stride),
            .i_limit  (r_limit),
            .i_ctrl   (s_ctrl[B+svag_pkg::IDX_BITS]),
            .i_word   (s_word[B+svag_pkg::IDX_BITS]),
            .i_rem    (s_rem[B+svag_pkg::IDX_BITS]),
            .i_at     (s_at[B+svag_pkg::IDX_BITS]),
            .o_ctrl   (s_ctrl[B+HOPS]),
            .o_word   (s_word[B+HOPS]),
            .o_rem    (s_rem[B+HOPS]),
            .o_at     (s_at[B+HOPS])
        );
    end

    // The index is in range when the quotient left after all axes is zero and no used axis has size zero.
    always_comb begin
        err_range = (s_word[NS] != '0) || (zero_hit != '0);
        if (err_range) begin
            n_status = svag_pkg::ST_RANGE;
        end else if ((r_base >= r_limit) || s_ctrl[NS].err) begin
            n_status = svag_pkg::ST_STORAGE;
        end else begin
            n_status = svag_pkg::ST_OK;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= s_ctrl[NS].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_pos    <= (n_status == svag_pkg::ST_OK) ? s_at[NS] : '0;
    end

    assign o_valid            = r_valid;
    assign o_status           = r_status;
    assign o_storage_position = r_pos;

    // Checks on the result path.
    `SVAG_ASSERT_IMP(a_status_code, i_clk, i_rst_n, o_valid, o_status != 2'd3)
    `SVAG_ASSERT_IMP(a_err_zero, i_clk, i_rst_n, o_valid && (o_status != svag_pkg::ST_OK), o_storage_position == '0)
    `SVAG_ASSERT_IMP(a_pos_in_storage, i_clk, i_rst_n, o_valid && (o_status == svag_pkg::ST_OK), o_storage_position < r_limit)
    `SVAG_ASSERT_NXT(a_chain_out, i_clk, i_rst_n, s_ctrl[NS].valid, o_valid)

endmodule

// ----- sv/svag_div_cell.sv -----
// One restoring division step: one quotient bit of the flat index per cell.
module svag_div_cell #(
    parameter int SIZE_BITS = svag_pkg::SIZE_BITS_DEF,
    parameter int POS_BITS  = svag_pkg::POS_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic [SIZE_BITS-1:0]          i_size,
    input  svag_pkg::t_ctrl               i_ctrl,
    input  logic [svag_pkg::IDX_BITS-1:0] i_word,
    input  logic [SIZE_BITS-1:0]          i_rem,
    input  logic [POS_BITS-1:0]           i_at,
    output svag_pkg::t_ctrl               o_ctrl,
    output logic [svag_pkg::IDX_BITS-1:0] o_word,
    output logic [SIZE_BITS-1:0]          o_rem,
    output logic [POS_BITS-1:0]           o_at
);

    logic                          r_valid;
    logic                          r_err;
    logic [svag_pkg::IDX_BITS-1:0] r_word, n_word;
    logic [SIZE_BITS-1:0]          r_rem, n_rem;
    logic [POS_BITS-1:0]           r_at;
    logic [SIZE_BITS:0]            trial;
    logic                          ge;

    // Shift the next dividend bit into the remainder and subtract when it fits.
    always_comb begin
        trial = {i_rem, i_word[svag_pkg::IDX_BITS-1]};
        ge    = (trial >= {1'b0, i_size});
        if (i_en) begin
            n_rem  = ge ? SIZE_BITS'(trial - {1'b0, i_size}) : SIZE_BITS'(trial);
            n_word = {i_word[svag_pkg::IDX_BITS-2:0], ge};
        end else begin
            n_rem  = i_rem;
            n_word = i_word;
        end
    end

    // Control register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_ctrl.valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_err  <= i_ctrl.err;
        r_word <= n_word;
        r_rem  <= n_rem;
        r_at   <= i_at;
    end

    assign o_ctrl.valid = r_valid;
    assign o_ctrl.err   = r_err;
    assign o_word       = r_word;
    assign o_rem        = r_rem;
    assign o_at         = r_at;

endmodule

// ----- sv/svag_mac_cell.sv -----
// Coordinate times stride, then add into the position with the storage check.
module svag_mac_cell #(
    parameter int SIZE_BITS   = svag_pkg::SIZE_BITS_DEF,
    parameter int STRIDE_BITS = svag_pkg::STRIDE_BITS_DEF,
    parameter int POS_BITS    = svag_pkg::POS_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [STRIDE_BITS-1:0]        i_stride,
    input  logic [POS_BITS-1:0]           i_limit,
    input  svag_pkg::t_ctrl               i_ctrl,
    input  logic [svag_pkg::IDX_BITS-1:0] i_word,
    input  logic [SIZE_BITS-1:0]          i_rem,
    input  logic [POS_BITS-1:0]           i_at,
    output svag_pkg::t_ctrl               o_ctrl,
    output logic [svag_pkg::IDX_BITS-1:0] o_word,
    output logic [SIZE_BITS-1:0]          o_rem,
    output logic [POS_BITS-1:0]           o_at
);

    localparam int PROD_BITS = SIZE_BITS + STRIDE_BITS;
    localparam int SUM_BITS  = ((PROD_BITS > POS_BITS) ? PROD_BITS : POS_BITS) + 1;

    logic                          r_v1, r_v2;
    logic                          r_e1, r_e2;
    logic [svag_pkg::IDX_BITS-1:0] r_w1, r_w2;
    logic [POS_BITS-1:0]           r_a1, r_a2;
    logic [PROD_BITS-1:0]          r_prod;
    logic [SUM_BITS-1:0]           sum;
    logic                          n_err;

    // Add the product and flag a position that reaches the storage limit.
    always_comb begin
        sum   = SUM_BITS'(r_a1) + SUM_BITS'(r_prod);
        n_err = r_e1 || (sum >= SUM_BITS'(i_limit));
    end

    // Control registers of both stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_ctrl.valid;
            r_v2 <= r_v1;
        end
    end

    // Multiply stage, then accumulate stage.
    always_ff @(posedge i_clk) begin
        r_prod <= PROD_BITS'(i_rem) * PROD_BITS'(i_stride);
        r_e1   <= i_ctrl.err;
        r_w1   <= i_word;
        r_a1   <= i_at;
        r_e2   <= n_err;
        r_w2   <= r_w1;
        r_a2   <= n_err ? r_a1 : POS_BITS'(sum);
    end

    assign o_ctrl.valid = r_v2;
    assign o_ctrl.err   = r_e2;
    assign o_word       = r_w2;
    assign o_rem        = '0;
    assign o_at         = r_a2;

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench of the strided view address generator.
`timescale 1ns / 100ps

module tb_top;

    localparam int LATENCY = 265;
    localparam int CYCLE_LIMIT = 400000;

    // Scoreboard: predicts each storage position and checks results in order.
    class position_board;
        logic [2:0]  rank_q;
        logic [47:0] base_q;
        logic [47:0] limit_q;
        logic [63:0] sizes_q;
        logic [63:0] str_lo_q;
        logic [63:0] str_hi_q;
        logic [47:0] pos_fifo[$];
        logic [1:0]  status_fifo[$];
        int          errors;

        function new();
            rank_q = '0;
            base_q = '0;
            limit_q = '0;
            sizes_q = '0;
            str_lo_q = '0;
            str_hi_q = '0;
            errors = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [63:0] value);
            case (idx)
                svag_pkg::REG_RANK:     rank_q = value[2:0];
                svag_pkg::REG_BASE:     base_q = value[47:0];
                svag_pkg::REG_LIMIT:    limit_q = value[47:0];
                svag_pkg::REG_SIZES:    sizes_q = value;
                svag_pkg::REG_STR_LOW:  str_lo_q = value;
                svag_pkg::REG_STR_HIGH: str_hi_q = value;
                default: ;
            endcase
        endfunction

        // Works out the expected result of one accepted request.
        function void note_request(logic [63:0] flat_index);
            int unsigned         axes;
            logic [127:0]        count;
            bit                  wide;
            logic [63:0]         rest;
            logic [63:0]         sz;
            logic [63:0]         st;
            logic [63:0]         coord;
            logic [63:0]         at;
            logic [63:0]         room;
            logic [1:0]          status;
            axes = (rank_q > 4) ? 4 : rank_q;
            count = 1;
            wide = 0;
            status = svag_pkg::ST_OK;
            for (int i = 0; i < axes; i++) begin
                sz = (sizes_q >> (16 * i)) & 64'hffff;
                if (sz == 0) begin
                    count = 0;
                    wide = 0;
                    break;
                end
                if (!wide) begin
                    count = count * sz;
                    if (count[127:64] != 0) wide = 1;
                end
            end
            at = 64'(base_q);
            rest = flat_index;
            if (!wide && flat_index >= count[63:0]) begin
                status = svag_pkg::ST_RANGE;
            end else if (base_q >= limit_q) begin
                status = svag_pkg::ST_STORAGE;
            end else begin
                for (int i = axes - 1; i >= 0; i--) begin
                    sz = (sizes_q >> (16 * i)) & 64'hffff;
                    st = (i < 2) ? ((str_lo_q >> (32 * i)) & 64'hffffffff)
                                 : ((str_hi_q >> (32 * (i - 2))) & 64'hffffffff);
                    coord = rest % sz;
                    rest = rest / sz;
                    room = 64'(limit_q) - 64'd1 - at;
                    if (st != 0) begin
                        if (coord > room / st) begin
                            status = svag_pkg::ST_STORAGE;
                            break;
                        end
                        at = at + coord * st;
                    end
                end
            end
            pos_fifo = {pos_fifo, ((status == svag_pkg::ST_OK) ? at[47:0] : 48'd0)};
            status_fifo = {status_fifo, status};
        endfunction

        task check_result(logic [47:0] pos, logic [1:0] status);
            logic [47:0] want_pos;
            logic [1:0]  want_status;
            if (pos_fifo.size() == 0) begin
                report_mismatch($sformatf("unexpected result pos=%0h status=%0d",
                                          pos, status));
                return;
            end
            want_pos = pos_fifo.pop_front();
            want_status = status_fifo.pop_front();
            if (status !== want_status)
                report_mismatch($sformatf("status %0d, expected %0d", status, want_status));
            if (pos !== want_pos)
                report_mismatch($sformatf("position %0h, expected %0h", pos, want_pos));
        endtask

        task report_mismatch(string text);
            errors++;
            $display("MISMATCH at %0t: %s", $time, text);
        endtask
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        start = 0;
    logic [63:0] i_flat_index = '0;
    logic        psel = 0;
    logic        penable = 0;
    logic        pwrite = 0;
    logic [5:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic        busy;
    logic        o_valid;
    logic [47:0] o_storage_position;
    logic [1:0]  o_status;
    logic [63:0] prdata;
    logic        pready;

    position_board board = new();
    int unsigned cycles = 0;
    int unsigned calm_left = 0;

    strided_view_address_gen_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_flat_index(i_flat_index), .o_valid(o_valid),
        .o_storage_position(o_storage_position), .o_status(o_status),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #1 i_clk = ~i_clk;

    // Result checking and the run limit.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && o_valid) board.check_result(o_storage_position, o_status);
        if (cycles > CYCLE_LIMIT) begin
            $display("** strided_view_address_gen_top: FAILED **");
            $finish;
        end
    end

    // Writes one register through the configuration port.
    task automatic write_reg(logic [2:0] idx, logic [63:0] value);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1;
        do @(posedge i_clk); while (!pready);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        board.set_reg(idx, value);
    endtask

    // Sends one request, with a random gap before it outside calm stretches.
    task automatic send_request(logic [63:0] flat_index);
        if (calm_left > 0) calm_left--;
        else while ($urandom_range(99) < 13) begin
            start <= 0;
            @(posedge i_clk);
        end
        start <= 1;
        i_flat_index <= flat_index;
        do @(posedge i_clk); while (busy);
        board.note_request(flat_index);
    endtask

    task automatic end_requests();
        start <= 0;
        @(posedge i_clk);
    endtask

    // Waits until every result is in, then lets the pipe drain.
    task automatic drain();
        end_requests();
        while (board.pos_fifo.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    // Picks a flat index mostly inside the view, sometimes near or past its end.
    function automatic logic [63:0] pick_index(logic [63:0] count);
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(9))
            0: return r;
            1: return count + 64'($urandom_range(3));
            2: return (count == 0) ? 64'd0 : count - 64'd1;
            default: return (count == 0) ? r : r % count;
        endcase
    endfunction

    function automatic logic [63:0] view_count();
        logic [63:0] c;
        int unsigned axes;
        c = 1;
        axes = (board.rank_q > 4) ? 4 : board.rank_q;
        for (int i = 0; i < axes; i++) c = c * ((board.sizes_q >> (16 * i)) & 64'hffff);
        return c;
    endfunction

    task automatic random_view();
        logic [63:0] sz;
        logic [63:0] st;
        logic [47:0] lim;
        sz = '0;
        for (int i = 0; i < 4; i++) sz[16 * i +: 16] = 16'($urandom_range(1, 9));
        if ($urandom_range(9) == 0) sz[16 * $urandom_range(3) +: 16] = 16'd0;
        if ($urandom_range(9) == 0) sz = {$urandom, $urandom};
        write_reg(svag_pkg::REG_SIZES, sz);
        st = {$urandom_range(0, 400), $urandom_range(0, 40)};
        if ($urandom_range(7) == 0) st = {$urandom, $urandom};
        write_reg(svag_pkg::REG_STR_LOW, st);
        st = {$urandom_range(0, 60000), $urandom_range(0, 4000)};
        if ($urandom_range(7) == 0) st = {$urandom, $urandom};
        write_reg(svag_pkg::REG_STR_HIGH, st);
        write_reg(svag_pkg::REG_RANK, 64'($urandom_range(0, 7)));
        write_reg(svag_pkg::REG_BASE, 64'($urandom_range(0, 5000)));
        lim = ($urandom_range(0, 3) == 0) ? 48'({$urandom, $urandom})
                                          : 48'($urandom_range(0, 20000000));
        write_reg(svag_pkg::REG_LIMIT, 64'(lim));
    endtask

    // Stimulus: directed corners, then random views and indexes.
    initial begin
        logic [63:0] count;
        int unsigned n;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Scalar view with empty storage, then with room.
        send_request(64'd0);
        send_request(64'hffff_ffff_ffff_ffff);
        drain();
        write_reg(svag_pkg::REG_LIMIT, 64'h0000_ffff_ffff_ffff);
        write_reg(svag_pkg::REG_BASE, 64'h0000_ffff_ffff_fffe);
        send_request(64'd0);
        send_request(64'd1);
        drain();
        // Full rank with largest sizes and strides: the count still fits in 64 bits.
        write_reg(svag_pkg::REG_RANK, 64'd7);
        write_reg(svag_pkg::REG_SIZES, 64'hffff_ffff_ffff_ffff);
        write_reg(svag_pkg::REG_STR_LOW, 64'hffff_ffff_ffff_ffff);
        write_reg(svag_pkg::REG_STR_HIGH, 64'hffff_ffff_ffff_ffff);
        write_reg(svag_pkg::REG_BASE, 64'd0);
        send_request(64'd0);
        send_request(64'hffff_ffff_ffff_ffff);
        send_request(64'h8000_0000_0000_0000);
        send_request(64'h0000_0000_0001_0000);
        drain();
        // Zero-sized axis, base at the limit, last position below the limit, zero strides.
        write_reg(svag_pkg::REG_RANK, 64'd2);
        write_reg(svag_pkg::REG_SIZES, 64'h0000_0000_0000_0005);
        send_request(64'd0);
        send_request(64'd3);
        drain();
        write_reg(svag_pkg::REG_SIZES, 64'h0000_0000_0004_0005);
        write_reg(svag_pkg::REG_STR_LOW, 64'h0000_0005_0000_0001);
        write_reg(svag_pkg::REG_BASE, 64'd20);
        write_reg(svag_pkg::REG_LIMIT, 64'd20);
        send_request(64'd0);
        drain();
        write_reg(svag_pkg::REG_LIMIT, 64'd40);
        send_request(64'd0);
        send_request(64'd19);
        send_request(64'd20);
        send_request(64'd4);
        drain();
        write_reg(svag_pkg::REG_STR_LOW, 64'd0);
        send_request(64'd19);
        drain();

        // Random phases; from the seventh on, a stretch of 200 requests goes without gaps.
        n = 0;
        for (int ph = 0; n < 1850; ph++) begin
            random_view();
            count = view_count();
            if (ph == 6) calm_left = 200;
            for (int k = 0; k < 60; k++) begin
                send_request(pick_index(count));
                n++;
            end
            drain();
        end
        if (board.errors == 0) begin
            $display("** strided_view_address_gen_top: PASSED **");
        end else begin
            $display("** strided_view_address_gen_top: FAILED **");
        end
        $finish;
    end
endmodule

// ----- files.f -----
+incdir+sv
sv/svag_pkg.sv
sv/svag_div_cell.sv
sv/svag_mac_cell.sv
sv/strided_view_address_gen_top.sv
verif/tb_top.sv
